// ===== rtl/core/fmsf_pkg.sv =====
// Package: shared types, constants and a saturating-add helper for the frame monitor.
package fmsf_pkg;

  localparam logic [15:0] HEADER_BYTES = 16'd16;
  localparam logic [15:0] SEQ_GAP_LIMIT = 16'hFFFF;
  localparam logic [15:0] CFG_RESET_BYTES = 16'd1024;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PT_UINT8 = 2'd0,
    PT_INT16 = 2'd1,
    PT_INT32 = 2'd2,
    PT_FLOAT = 2'd3
  } ptype_t;

  typedef enum logic {
    FN_HEADER = 1'b0,
    FN_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [15:0] seq_no;
    logic [1:0]  elem_type;
    logic [15:0] frame_bytes;
    logic [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        is_sample;
    logic [31:0] float_bits;
    logic [31:0] lost_frames;
    logic [31:0] bad_frames;
    logic [31:0] broken_frames;
  } out_item_t;

  // Saturating add of a 32-bit counter and a 16-bit increment.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    sat_add = s[32] ? CNT_MAX : s[31:0];
  endfunction

endpackage

// ===== rtl/core/fmsf_i2f.sv =====
// Integer to IEEE single conversion with round to nearest even.
module fmsf_i2f (
  input  logic [31:0] in_int,
  output logic [31:0] out_bits
);
  import fmsf_pkg::*;

  logic        sign;
  logic [31:0] mag;
  logic [4:0]  lz;
  logic [31:0] norm;
  logic [24:0] mant_rnd;
  logic        guard;
  logic        sticky;
  logic [7:0]  expo;

  // Sign and magnitude of the two's complement input.
  assign sign = in_int[31];
  assign mag  = sign ? (~in_int + 32'd1) : in_int;

  // Leading zero count of the magnitude.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
  end

  // Normalize, round on guard/sticky, bump exponent on carry.
  always_comb begin
    norm     = mag << lz;
    guard    = norm[7];
    sticky   = |norm[6:0];
    mant_rnd = {1'b0, norm[31:8]} +
               {24'd0, guard & (sticky | norm[8])};
    expo     = 8'd158 - {3'd0, lz} + {7'd0, mant_rnd[24]};
    if (mag == 32'd0) begin
      out_bits = 32'd0;
    end else if (mant_rnd[24]) begin
      out_bits = {sign, expo, mant_rnd[23:1]};
    end else begin
      out_bits = {sign, expo, mant_rnd[22:0]};
    end
  end

endmodule

// ===== rtl/core/fmsf_hdr.sv =====
// Header checks: next values of the lost, bad and broken frame counters.
module fmsf_hdr (
  input  fmsf_pkg::in_item_t item,
  input  logic [15:0]        exp_bytes,
  input  logic               seen,
  input  logic [15:0]        last_cnt,
  input  logic [31:0]        lost_in,
  input  logic [31:0]        bad_in,
  input  logic [31:0]        broken_in,
  output logic [31:0]        lost_out,
  output logic [31:0]        bad_out,
  output logic [31:0]        broken_out
);
  import fmsf_pkg::*;

  logic [15:0] delta;
  logic [15:0] pay;
  logic        broken;

  // Gap in the counter sequence; only forward gaps under 65535 count.
  always_comb begin
    delta = item.seq_no - last_cnt;
    if (seen && item.seq_no > last_cnt && delta > 16'd1 && delta != SEQ_GAP_LIMIT)
      lost_out = sat_add(lost_in, delta - 16'd1);
    else
      lost_out = lost_in;
  end

  assign bad_out = (item.frame_bytes != exp_bytes) ? sat_add(bad_in, 16'd1) : bad_in;

  // Payload size consistency.
  always_comb begin
    pay = item.frame_bytes - HEADER_BYTES;
    unique case (ptype_t'(item.elem_type))
      PT_UINT8: broken = 1'b0;
      PT_INT16: broken = pay[0];
      default:  broken = |pay[1:0];
    endcase
    if (item.frame_bytes <= HEADER_BYTES) broken = 1'b1;
  end

  assign broken_out = broken ? sat_add(broken_in, 16'd1) : broken_in;

endmodule

// ===== rtl/core/frame_monitor_sample_to_float.sv =====
// Top level: frame monitor with sample to float conversion.
// Takes one transaction per cycle while in_stall is low and gives one result per
// transaction: an input register feeds a single combinational pass
// (header checks or integer-to-float conversion) into the result register,
// which a skid register backs when out_stall is asserted. The rate of one
// transaction per cycle is set by that one-pass datapath. Configuration is
// always ready; write it only while no transaction is in flight.
module frame_monitor_sample_to_float (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmsf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmsf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import fmsf_pkg::*;

  logic [15:0] exp_bytes_r;
  logic        seen_r;
  logic [15:0] last_cnt_r;
  logic [1:0]  type_r;
  logic [31:0] lost_r, bad_r, broken_r;
  logic [31:0] lost_nxt, bad_nxt, broken_nxt;
  in_item_t    in_r;
  logic        in_v_r;
  out_item_t   res_nxt, res_r, skid_r;
  logic        res_v_r, skid_v_r;
  logic [31:0] conv_in, conv_out;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  // Stage advances unless the result slot is blocked.
  assign adv       = !(res_v_r && out_stall);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!skid_v_r) begin
      in_v_r <= in_valid;
      in_r   <= in_data;
    end
  end

  // Sample widening per latched type.
  always_comb begin
    unique case (ptype_t'(type_r))
      PT_UINT8: conv_in = {24'd0, in_r.sample[7:0]};
      PT_INT16: conv_in = {{16{in_r.sample[15]}}, in_r.sample[15:0]};
      default:  conv_in = in_r.sample;
    endcase
  end

  fmsf_i2f u_i2f (.in_int(conv_in), .out_bits(conv_out));

  fmsf_hdr u_hdr (
    .item(in_r), .exp_bytes(exp_bytes_r), .seen(seen_r), .last_cnt(last_cnt_r),
    .lost_in(lost_r), .bad_in(bad_r), .broken_in(broken_r),
    .lost_out(lost_nxt), .bad_out(bad_nxt), .broken_out(broken_nxt)
  );

  // Result assembly.
  always_comb begin
    res_nxt.is_sample = in_r.func;
    if (in_r.func == FN_SAMPLE) begin
      res_nxt.float_bits    = (ptype_t'(type_r) == PT_FLOAT) ? in_r.sample : conv_out;
      res_nxt.lost_frames   = lost_r;
      res_nxt.bad_frames    = bad_r;
      res_nxt.broken_frames = broken_r;
    end else begin
      res_nxt.float_bits    = 32'd0;
      res_nxt.lost_frames   = lost_nxt;
      res_nxt.bad_frames    = bad_nxt;
      res_nxt.broken_frames = broken_nxt;
    end
  end

  // State update when a header is processed, and on configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bytes_r <= CFG_RESET_BYTES;
      seen_r      <= 1'b0;
      last_cnt_r  <= 16'd0;
      type_r      <= 2'd0;
      lost_r      <= 32'd0;
      bad_r       <= 32'd0;
      broken_r    <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) exp_bytes_r <= cfg_data;
      if (in_v_r && !skid_v_r && in_r.func == FN_HEADER) begin
        seen_r     <= 1'b1;
        last_cnt_r <= in_r.seq_no;
        type_r     <= in_r.elem_type;
        lost_r     <= lost_nxt;
        bad_r      <= bad_nxt;
        broken_r   <= broken_nxt;
      end
    end
  end

  // Result register with skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) begin
        res_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (adv) begin
      res_v_r <= in_v_r;
      res_r   <= res_nxt;
    end else if (in_v_r) begin
      skid_v_r <= 1'b1;
      skid_r   <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

  // Skid holds data only while the output is full.
  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> res_v_r) else $error("skid valid with empty output");
  // No input is taken while the skid is occupied.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> in_stall) else $error("input taken with skid full");
  // The lost-frame counter never decreases.
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> lost_r >= $past(lost_r)) else $error("lost counter went back");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for frame_monitor_sample_to_float: directed and random frames checked against a predictor.
class frame_scoreboard;
  logic [15:0] exp_bytes;
  bit seen;
  logic [15:0] last_cnt;
  fmsf_pkg::ptype_t cur_type;
  logic [31:0] lost_cnt, bad_cnt, broken_cnt;
  fmsf_pkg::out_item_t pending_results[$];
  int errors;

  function new();
    exp_bytes = fmsf_pkg::CFG_RESET_BYTES;
    seen = 0; last_cnt = 0; cur_type = fmsf_pkg::PT_UINT8;
    lost_cnt = 0; bad_cnt = 0; broken_cnt = 0; errors = 0;
  endfunction

  function logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Signed 32-bit integer to single precision bits, round to nearest even.
  function logic [31:0] to_single(logic [31:0] x);
    logic [31:0] mag, m, rem, half;
    logic [7:0] e;
    int p, sh;
    mag = x[31] ? (~x + 32'd1) : x;
    if (mag == 0) return 32'd0;
    p = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = i;
    e = 8'(127 + p);
    if (p <= 23) m = mag << (23 - p);
    else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      m = mag >> sh;
      if (rem > half || (rem == half && m[0])) m++;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        e++;
      end
    end
    return {x[31], e, m[22:0]};
  endfunction

  function void note_input(fmsf_pkg::in_item_t it);
    fmsf_pkg::out_item_t r;
    int gap;
    logic [15:0] pay;
    r = '0;
    r.is_sample = it.func;
    if (it.func == fmsf_pkg::FN_HEADER) begin
      if (seen) begin
        gap = int'(it.seq_no) - int'(last_cnt);
        if (gap > 1 && gap < 65535) lost_cnt = sat_inc(lost_cnt, 32'(gap - 1));
      end
      seen = 1;
      last_cnt = it.seq_no;
      cur_type = fmsf_pkg::ptype_t'(it.elem_type);
      if (it.frame_bytes != exp_bytes) bad_cnt = sat_inc(bad_cnt, 32'd1);
      if (it.frame_bytes > fmsf_pkg::HEADER_BYTES) begin
        pay = it.frame_bytes - fmsf_pkg::HEADER_BYTES;
        if ((cur_type == fmsf_pkg::PT_INT16 && pay[0]) ||
            ((cur_type == fmsf_pkg::PT_INT32 || cur_type == fmsf_pkg::PT_FLOAT) && pay[1:0] != 0))
          broken_cnt = sat_inc(broken_cnt, 32'd1);
      end else broken_cnt = sat_inc(broken_cnt, 32'd1);
    end else begin
      case (cur_type)
        fmsf_pkg::PT_UINT8: r.float_bits = to_single({24'd0, it.sample[7:0]});
        fmsf_pkg::PT_INT16: r.float_bits = to_single({{16{it.sample[15]}}, it.sample[15:0]});
        fmsf_pkg::PT_INT32: r.float_bits = to_single(it.sample);
        default: r.float_bits = it.sample;
      endcase
    end
    r.lost_frames = lost_cnt;
    r.bad_frames = bad_cnt;
    r.broken_frames = broken_cnt;
    pending_results = {pending_results, r};
  endfunction

  function void check_result(fmsf_pkg::out_item_t got);
    fmsf_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.is_sample !== want.is_sample || got.float_bits !== want.float_bits ||
        got.lost_frames !== want.lost_frames || got.bad_frames !== want.bad_frames ||
        got.broken_frames !== want.broken_frames) begin
      $display("%0t: mismatch expected %h actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import fmsf_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [15:0] cfg_data;

  frame_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_recv;
  int cycles;
  logic [15:0] frame_seq;

  frame_monitor_sample_to_float u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1; #10;
    clk = 0; #10;
  end

  // Receiver: random stall, long hold-off on request; check at rising edge.
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycles > 400000) begin
      $display("frame_monitor_sample_to_float test failed");
      $finish;
    end
  end

  // Offers one transaction, holding it until accepted.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.exp_bytes = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic in_item_t header(logic [15:0] cnt, logic [1:0] pt, logic [15:0] nb);
    in_item_t it;
    it = 67'({$urandom, $urandom, $urandom});
    it.func = FN_HEADER;
    it.seq_no = cnt;
    it.elem_type = pt;
    it.frame_bytes = nb;
    return it;
  endfunction

  function automatic in_item_t sample_of(logic [31:0] s);
    in_item_t it;
    it = 67'({$urandom, $urandom, $urandom});
    it.func = FN_SAMPLE;
    it.sample = s;
    return it;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(255);
      1: return 32'h7FFF_FF00 | $urandom_range(255);
      2: return $urandom_range(65535);
      3: return 32'h0100_0000 | ($urandom << $urandom_range(8));
      default: return $urandom;
    endcase
  endfunction

  // A well-formed frame usually; occasionally broken or out of sequence.
  task automatic random_frame();
    logic [1:0] pt;
    logic [15:0] nb;
    int n;
    pt = 2'($urandom_range(3));
    nb = sb.exp_bytes;
    if ($urandom_range(9) < 3)
      nb = ($urandom_range(3) == 0) ? 16'($urandom_range(32)) : 16'($urandom);
    if ($urandom_range(9) == 0) frame_seq = 16'($urandom);
    else if ($urandom_range(9) == 0) frame_seq = frame_seq + 16'($urandom_range(5));
    else frame_seq++;
    send_item(header(frame_seq, pt, nb));
    n = $urandom_range(8);
    repeat (n) send_item(sample_of(rand_sample()));
  endtask

  task automatic random_phase(int idle, int stall, int frames);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (frames) random_frame();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    cfg_valid = 0; cfg_data = 0; hold_recv = 0;
    send_idle_pct = 0; recv_stall_pct = 0; frame_seq = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: sample before any header, conversion extremes, counter cases.
    send_item(sample_of(32'hFFFF_FF00));
    send_item(sample_of(32'h0000_00FF));
    send_item(header(16'd10, PT_INT16, 16'd1024));
    send_item(sample_of(32'h0000_8000));
    send_item(sample_of(32'h0000_7FFF));
    send_item(sample_of(32'hFFFF_0000));
    send_item(header(16'd13, PT_INT32, 16'd16));
    send_item(sample_of(32'h8000_0000));
    send_item(sample_of(32'h7FFF_FFFF));
    send_item(sample_of(32'h0100_0003));
    send_item(sample_of(32'h0100_0001));
    send_item(sample_of(32'hFFFF_FFFF));
    send_item(header(16'd12, PT_FLOAT, 16'd18));
    send_item(sample_of(32'h7FC0_1234));
    send_item(header(16'hFFFF, PT_UINT8, 16'd17));
    send_item(sample_of(32'h0));
    send_item(header(16'd0, PT_INT16, 16'd19));
    send_item(header(16'hFFFE, PT_INT32, 16'hFFFF));
    send_item(header(16'd0, PT_UINT8, 16'd0));
    drain();

    write_cfg(16'd0);
    random_phase(0, 0, 70);
    drain();
    write_cfg(16'hFFFF);
    random_phase(77, 0, 70);
    drain();
    write_cfg(16'd64);
    random_phase(0, 77, 70);
    drain();
    write_cfg(16'd1024);
    random_phase(33, 33, 70);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_recv = 1;
        repeat (200) @(negedge clk);
        hold_recv = 0;
      end
      random_phase(0, 0, 20);
    join
    drain();
    write_cfg(16'd20);
    random_phase(0, 0, 40);
    drain();
    // Push the loss counter toward saturation.
    for (int i = 0; i < 40; i++) begin
      send_item(header(16'd0, PT_UINT8, 16'd20));
      send_item(header(16'hFFF0, PT_UINT8, 16'd20));
    end
    frame_seq = 16'hFFF0;
    random_phase(10, 10, 30);

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("frame_monitor_sample_to_float test passed");
    else
      $display("frame_monitor_sample_to_float test failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/fmsf_pkg.sv
rtl/core/fmsf_i2f.sv
rtl/core/fmsf_hdr.sv
rtl/core/frame_monitor_sample_to_float.sv
bench/tb_top.sv
